### rtl/bda_pkg.sv
// Shared types and codes for the banker's device allocator.
// No dependencies; bda_ctrl, bda_dpath and the top level use this package.
`default_nettype none

package bda_pkg;

  localparam int unsigned DEV_W = 8;

  typedef enum logic [1:0] {
    FN_ADMIT   = 2'd0,
    FN_REQUEST = 2'd1,
    FN_RELEASE = 2'd2,
    FN_FINISH  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    RS_DONE   = 2'd0,
    RS_DEFER  = 2'd1,
    RS_LATE   = 2'd2,
    RS_REJECT = 2'd3
  } res_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [3:0]       slot;
    logic [DEV_W-1:0] count;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       result_slot;
    logic [1:0]       status;
    logic [DEV_W-1:0] free_devices;
    logic             last;
  } out_item_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CHECK,
    OP_SAFE_INIT,
    OP_SAFE_STEP,
    OP_REQ_END,
    OP_RT_ADDR,
    OP_RT_CHECK,
    OP_RT_GRANT,
    OP_RT_NEXT,
    OP_FLUSH
  } op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic need_safe;
    logic go_retry;
    logic rt_try;
    logic idx_last;
    logic sw_end;
    logic sw_safe;
    logic out_free;
    logic hold_valid;
  } sts_t;

endpackage

`default_nettype wire

### rtl/bda_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bda_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/bda_ctrl.sv
// Sequencer for the allocator: steps the datapath through check, safety pass and retry.
// Depends on bda_pkg.
`default_nettype none

module bda_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bda_pkg::sts_t sts,
  output bda_pkg::op_t       op
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SINIT,
    S_SSTEP,
    S_REQEND,
    S_RADDR,
    S_RCHECK,
    S_RGRANT,
    S_RNEXT,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   mode_r, mode_nxt;   // 1: safety pass runs for a retry

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    op        = bda_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = bda_pkg::OP_ACCEPT;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        op = bda_pkg::OP_CHECK;
        if (sts.need_safe) begin
          mode_nxt  = 1'b0;
          state_nxt = S_SINIT;
        end else if (sts.go_retry) begin
          state_nxt = S_RADDR;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_SINIT: begin
        op        = bda_pkg::OP_SAFE_INIT;
        state_nxt = S_SSTEP;
      end
      S_SSTEP: begin
        op = bda_pkg::OP_SAFE_STEP;
        if (sts.sw_end) begin
          if (!mode_r) begin
            state_nxt = S_REQEND;
          end else if (sts.sw_safe) begin
            state_nxt = S_RGRANT;
          end else begin
            state_nxt = S_RNEXT;
          end
        end
      end
      S_REQEND: begin
        op        = bda_pkg::OP_REQ_END;
        state_nxt = S_FLUSH;
      end
      S_RADDR: begin
        op        = bda_pkg::OP_RT_ADDR;
        state_nxt = S_RCHECK;
      end
      S_RCHECK: begin
        op = bda_pkg::OP_RT_CHECK;
        if (sts.rt_try) begin
          mode_nxt  = 1'b1;
          state_nxt = S_SINIT;
        end else begin
          state_nxt = S_RNEXT;
        end
      end
      S_RGRANT: begin
        if (sts.out_free) begin
          op        = bda_pkg::OP_RT_GRANT;
          state_nxt = S_RNEXT;
        end
      end
      S_RNEXT: begin
        op        = bda_pkg::OP_RT_NEXT;
        state_nxt = sts.idx_last ? S_FLUSH : S_RADDR;
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          op        = bda_pkg::OP_FLUSH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

`default_nettype wire

### rtl/bda_dpath.sv
// Allocator datapath: slot tables in RAM, free count, safety sweep, result staging.
// Depends on bda_pkg and bda_ram.
`default_nettype none

module bda_dpath #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [bda_pkg::DEV_W-1:0]   cfg_wdata,
  input  wire bda_pkg::in_item_t           in_data,
  input  wire bda_pkg::op_t                op,
  output bda_pkg::sts_t                    sts,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output bda_pkg::out_item_t               out_data
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned AW = 9 + SW;   // free plus every held count
  localparam int unsigned DW = bda_pkg::DEV_W;

  function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DW] ? {DW{1'b1}} : s[DW-1:0];
  endfunction

  // RAM ports
  logic [DW-1:0] rd_claim, rd_held, rd_pend;
  logic          we_claim, we_held, we_pend;
  logic [DW-1:0] wd_claim, wd_held, wd_pend;
  logic [SW-1:0] raddr;

  // Control state
  logic [SLOTS-1:0] active_r, active_nxt;
  logic [DW-1:0]    total_r, total_nxt;
  logic [DW-1:0]    free_r, free_nxt;
  logic             hold_valid_r, hold_valid_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Working registers
  bda_pkg::in_item_t  req_r, req_nxt;
  logic [SW-1:0]      cand_r, cand_nxt;
  logic [DW-1:0]      amt_r, amt_nxt;
  logic [DW-1:0]      held_s_r, held_s_nxt;
  logic [SLOTS-1:0]   done_r, done_nxt;
  logic [AW-1:0]      avail_r, avail_nxt;
  logic               prog_r, prog_nxt;
  logic [SW-1:0]      sidx_r, sidx_nxt;
  logic [SW-1:0]      idx_r, idx_nxt;
  logic               safe_r, safe_nxt;
  bda_pkg::out_item_t hold_r, hold_nxt;
  bda_pkg::out_item_t out_r, out_nxt;

  bda_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_claim (
    .clk(clk), .we(we_claim), .waddr(cand_r), .wdata(wd_claim), .raddr(raddr), .rdata(rd_claim)
  );
  bda_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_held (
    .clk(clk), .we(we_held), .waddr(cand_r), .wdata(wd_held), .raddr(raddr), .rdata(rd_held)
  );
  bda_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_pend (
    .clk(clk), .we(we_pend), .waddr(cand_r), .wdata(wd_pend), .raddr(raddr), .rdata(rd_pend)
  );

  // Item checks
  logic          in_range, act_s;
  logic [DW:0]   held_cnt;
  logic          admit_ok, req_ok, rel_ok, fin_ok;
  logic [DW-1:0] free_rel, free_fin;
  bda_pkg::func_t fn;

  assign fn       = bda_pkg::func_t'(req_r.func);
  assign in_range = (32'(req_r.slot) < 32'(SLOTS));
  assign act_s    = active_r[cand_r];
  assign held_cnt = {1'b0, rd_held} + {1'b0, req_r.count};
  assign admit_ok = in_range && !act_s && (req_r.count <= total_r);
  assign req_ok   = in_range && act_s && (rd_pend == '0) && (held_cnt <= {1'b0, rd_claim});
  assign rel_ok   = in_range && act_s && (req_r.count <= rd_held);
  assign fin_ok   = in_range && act_s;
  assign free_rel = sat_add(free_r, req_r.count);
  assign free_fin = sat_add(free_r, rd_held);

  // One slot of the safety sweep per cycle
  logic [DW:0]      held_k, need_k;
  logic             fit, prog_now, all_done, sidx_last;
  logic [SLOTS-1:0] done_upd;

  always_comb begin
    held_k = {1'b0, rd_held} + ((sidx_r == cand_r) ? {1'b0, amt_r} : '0);
    need_k = ({1'b0, rd_claim} > held_k) ? ({1'b0, rd_claim} - held_k) : '0;
    fit    = !done_r[sidx_r] && (AW'(need_k) <= avail_r);
    for (int i = 0; i < SLOTS; i++) begin
      done_upd[i] = done_r[i] | (fit && (sidx_r == SW'(i)));
    end
    all_done  = &done_upd;
    prog_now  = prog_r | fit;
    sidx_last = (sidx_r == SW'(SLOTS - 1));
  end

  // Staging and output strobes
  logic          stage, push, push_last;
  logic [3:0]    st_slot;
  logic [1:0]    st_stat;
  logic [DW-1:0] st_free;

  always_comb begin
    active_nxt = active_r;
    total_nxt  = total_r;
    free_nxt   = free_r;
    req_nxt    = req_r;
    cand_nxt   = cand_r;
    amt_nxt    = amt_r;
    held_s_nxt = held_s_r;
    done_nxt   = done_r;
    avail_nxt  = avail_r;
    prog_nxt   = prog_r;
    sidx_nxt   = sidx_r;
    idx_nxt    = idx_r;
    safe_nxt   = safe_r;
    we_claim   = 1'b0;
    we_held    = 1'b0;
    we_pend    = 1'b0;
    wd_claim   = '0;
    wd_held    = '0;
    wd_pend    = '0;
    raddr      = cand_r;
    stage      = 1'b0;
    push       = 1'b0;
    push_last  = 1'b0;
    st_slot    = req_r.slot;
    st_stat    = bda_pkg::RS_REJECT;
    st_free    = free_r;

    unique case (op)
      bda_pkg::OP_ACCEPT: begin
        req_nxt  = in_data;
        cand_nxt = SW'(in_data.slot);
        amt_nxt  = in_data.count;
        raddr    = SW'(in_data.slot);
      end
      bda_pkg::OP_CHECK: begin
        idx_nxt    = '0;
        held_s_nxt = rd_held;
        stage      = 1'b1;
        unique case (fn)
          bda_pkg::FN_ADMIT: begin
            if (admit_ok) begin
              we_claim             = 1'b1;
              we_held              = 1'b1;
              we_pend              = 1'b1;
              wd_claim             = req_r.count;
              active_nxt[cand_r]   = 1'b1;
              st_stat              = bda_pkg::RS_DONE;
            end
          end
          bda_pkg::FN_REQUEST: begin
            if (req_ok) begin
              if (req_r.count == '0) begin
                st_stat = bda_pkg::RS_DONE;
              end else if (req_r.count > free_r) begin
                we_pend = 1'b1;
                wd_pend = req_r.count;
                st_stat = bda_pkg::RS_DEFER;
              end else begin
                stage = 1'b0;   // decided after the safety pass
              end
            end
          end
          bda_pkg::FN_RELEASE: begin
            if (rel_ok) begin
              we_held  = 1'b1;
              wd_held  = rd_held - req_r.count;
              free_nxt = free_rel;
              st_free  = free_rel;
              st_stat  = bda_pkg::RS_DONE;
            end
          end
          bda_pkg::FN_FINISH: begin
            if (fin_ok) begin
              we_held            = 1'b1;
              we_pend            = 1'b1;
              active_nxt[cand_r] = 1'b0;
              free_nxt           = free_fin;
              st_free            = free_fin;
              st_stat            = bda_pkg::RS_DONE;
            end
          end
          default: ;
        endcase
      end
      bda_pkg::OP_SAFE_INIT: begin
        raddr     = '0;
        sidx_nxt  = '0;
        done_nxt  = ~active_r;
        avail_nxt = AW'(free_r) - AW'(amt_r);
        prog_nxt  = 1'b0;
      end
      bda_pkg::OP_SAFE_STEP: begin
        raddr     = sidx_last ? '0 : sidx_r + 1'b1;
        done_nxt  = done_upd;
        avail_nxt = fit ? (avail_r + AW'(held_k)) : avail_r;
        prog_nxt  = sidx_last ? 1'b0 : prog_now;
        sidx_nxt  = sidx_last ? '0 : sidx_r + 1'b1;
        safe_nxt  = all_done;
      end
      bda_pkg::OP_REQ_END: begin
        stage = 1'b1;
        if (safe_r) begin
          we_held  = 1'b1;
          wd_held  = held_s_r + amt_r;
          free_nxt = free_r - amt_r;
          st_free  = free_r - amt_r;
          st_stat  = bda_pkg::RS_DONE;
        end else begin
          we_pend = 1'b1;
          wd_pend = amt_r;
          st_stat = bda_pkg::RS_DEFER;
        end
      end
      bda_pkg::OP_RT_ADDR: begin
        raddr = idx_r;
      end
      bda_pkg::OP_RT_CHECK: begin
        cand_nxt   = idx_r;
        amt_nxt    = rd_pend;
        held_s_nxt = rd_held;
      end
      bda_pkg::OP_RT_GRANT: begin
        push     = 1'b1;
        we_held  = 1'b1;
        wd_held  = held_s_r + amt_r;
        we_pend  = 1'b1;
        free_nxt = free_r - amt_r;
        stage    = 1'b1;
        st_slot  = 4'(cand_r);
        st_stat  = bda_pkg::RS_LATE;
        st_free  = free_r - amt_r;
      end
      bda_pkg::OP_RT_NEXT: begin
        idx_nxt = idx_r + 1'b1;
      end
      bda_pkg::OP_FLUSH: begin
        push      = 1'b1;
        push_last = 1'b1;
      end
      default: ;
    endcase

    if (cfg_we) begin
      total_nxt = cfg_wdata;
      free_nxt  = cfg_wdata;
    end
  end

  // Result staging: a result leaves only once it is known whether it is the last one
  always_comb begin
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (push) begin
      out_nxt       = hold_r;
      out_nxt.last  = push_last;
      out_valid_nxt = 1'b1;
      hold_valid_nxt = 1'b0;
    end
    if (stage) begin
      hold_nxt.result_slot  = st_slot;
      hold_nxt.status       = st_stat;
      hold_nxt.free_devices = st_free;
      hold_nxt.last         = 1'b0;
      hold_valid_nxt        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= '0;
      total_r      <= '0;
      free_r       <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      active_r     <= active_nxt;
      total_r      <= total_nxt;
      free_r       <= free_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    cand_r   <= cand_nxt;
    amt_r    <= amt_nxt;
    held_s_r <= held_s_nxt;
    done_r   <= done_nxt;
    avail_r  <= avail_nxt;
    prog_r   <= prog_nxt;
    sidx_r   <= sidx_nxt;
    idx_r    <= idx_nxt;
    safe_r   <= safe_nxt;
    hold_r   <= hold_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    sts.need_safe  = (fn == bda_pkg::FN_REQUEST) && req_ok && (req_r.count != '0) &&
                     (req_r.count <= free_r);
    sts.go_retry   = ((fn == bda_pkg::FN_RELEASE) && rel_ok) ||
                     ((fn == bda_pkg::FN_FINISH) && fin_ok);
    sts.rt_try     = active_r[idx_r] && (rd_pend != '0) && (rd_pend <= free_r);
    sts.idx_last   = (idx_r == SW'(SLOTS - 1));
    sts.sw_end     = all_done || (sidx_last && !prog_now);
    sts.sw_safe    = all_done;
    sts.out_free   = !out_valid_r || out_ready;
    sts.hold_valid = hold_valid_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### rtl/bankers_device_allocator_unit.sv
// Banker's device allocator, top level. Admit, reject and zero requests are decided in the
// check step; a checked request adds a safety pass (pass setup, sweeps of one table slot per
// cycle until all slots are done or a sweep makes no progress, the decision step); a release
// or finish adds a retry scan of every slot (address, check, next), plus for each waiting
// request tried a safety pass and a grant step when it is granted. The unit takes one
// request at a time. Reset (rst_n, synchronous): slots inactive, free count and pool size zero.
`default_nettype none

module bankers_device_allocator_unit #(
  parameter int unsigned SLOTS = 16   // process slots, 2 to 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // configuration: pool size, also reloads the free count
  input  wire logic                      cfg_we,
  input  wire logic [bda_pkg::DEV_W-1:0] cfg_wdata,
  // request channel
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire bda_pkg::in_item_t         in_data,
  // result channel
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output bda_pkg::out_item_t             out_data
);

  bda_pkg::op_t  op;
  bda_pkg::sts_t sts;

  // Controller: check, optional safety pass, then in-order retry of waiting requests
  bda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .op       (op)
  );

  // Datapath: claim/held/pending tables live in RAM, one slot read per cycle.
  // Each result is staged one step behind so the final one can carry the last flag.
  bda_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .op        (op),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // An accepted request always goes straight to its check
  a_accept_check : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> op == bda_pkg::OP_CHECK)
    else $error("accepted request not checked");

  // Nothing may be left staged while waiting for a new request
  a_idle_empty : assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.hold_valid)
    else $error("staged result left behind");

  // The final flush returns to idle and presents a last-marked result
  a_flush_last : assert property (@(posedge clk) disable iff (!rst_n)
    op == bda_pkg::OP_FLUSH |=> in_ready && out_valid && out_data.last)
    else $error("flush did not end the request");

endmodule

`default_nettype wire
